// File: rtl/cir_pkg.sv
// Shared types, codes and fixed-point helpers for the contact impulse resolver.
// No dependencies; imported by every module of the block.
package cir_pkg;

  localparam int BODY_SLOTS_DEF = 1024;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  localparam logic [2:0] KIND_WR_VEL  = 3'd0;
  localparam logic [2:0] KIND_WR_POS  = 3'd1;
  localparam logic [2:0] KIND_WR_MAT  = 3'd2;
  localparam logic [2:0] KIND_RESOLVE = 3'd3;
  localparam logic [2:0] KIND_READ    = 3'd4;
  localparam logic [2:0] KIND_CLEAR   = 3'd5;

  localparam logic [2:0] STAT_DONE       = 3'd0;
  localparam logic [2:0] STAT_APPLIED    = 3'd1;
  localparam logic [2:0] STAT_MISSING    = 3'd2;
  localparam logic [2:0] STAT_IMMOVABLE  = 3'd3;
  localparam logic [2:0] STAT_SEPARATING = 3'd4;

  localparam logic REG_CORR_FRAC = 1'b0;
  localparam logic REG_SLOP      = 1'b1;

  localparam logic [16:0] CORR_FRAC_RST = 17'd52429;
  localparam logic [16:0] SLOP_RST      = 17'd655;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] inv_mass;
    logic [16:0]        restitution;
    logic signed [31:0] static_fric;
    logic signed [31:0] dyn_fric;
    logic               valid;
  } body_t;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] pen;
    logic               same;
  } contact_t;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return Q_MAX;
    if (v < -34'sd2147483648) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat34(34'(a) + 34'(b));
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat34(34'(a) - 34'(b));
  endfunction

  // Q16.16 product from a full 64-bit product, truncated toward zero
  function automatic logic signed [31:0] qmul_of(input logic signed [63:0] p);
    logic signed [63:0] sh;
    sh = (p < 0) ? ((p + 64'sd65535) >>> 16) : (p >>> 16);
    if (sh > 64'sd2147483647) return Q_MAX;
    if (sh < -64'sd2147483648) return Q_MIN;
    return sh[31:0];
  endfunction

endpackage

// File: rtl/cir_div.sv
// Iterative Q16.16 divider, one quotient bit per cycle, saturating.
// Depends on cir_pkg.
module cir_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic signed [31:0] divisor,
  output logic               done,
  output logic signed [31:0] quotient
);
  import cir_pkg::*;

  localparam int DIV_STEPS = 48;
  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      rem;
  logic [47:0]      quo;
  logic [31:0]      den;
  logic             neg;
  logic             a_neg;
  logic             zero;

  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        ge;
  logic [47:0] quo_neg;

  assign mag_a  = dividend[31] ? (~dividend + 32'd1) : dividend;
  assign mag_b  = divisor[31] ? (~divisor + 32'd1) : divisor;
  assign rem_sh = {rem, quo[47]};
  assign ge     = rem_sh >= {1'b0, den};
  assign diff   = rem_sh - {1'b0, den};
  assign quo_neg = 48'd0 - quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        done  <= 1'b0;
        busy  <= 1'b1;
        cnt   <= CNT_W'(DIV_STEPS);
        rem   <= '0;
        quo   <= {mag_a, 16'd0};
        den   <= mag_b;
        neg   <= dividend[31] ^ divisor[31];
        a_neg <= dividend[31];
        zero  <= (divisor == 32'sd0);
      end else if (busy) begin
        rem  <= ge ? diff[31:0] : rem_sh[31:0];
        quo  <= {quo[46:0], ge};
        cnt  <= cnt - CNT_W'(1);
        done <= (cnt == CNT_W'(1));
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_comb begin
    if (zero) begin
      quotient = a_neg ? Q_MIN : Q_MAX;
    end else if (neg) begin
      quotient = (quo > 48'd2147483648) ? Q_MIN : quo_neg[31:0];
    end else begin
      quotient = (quo > 48'd2147483647) ? Q_MAX : quo[31:0];
    end
  end

endmodule

// File: rtl/cir_sqrt.sv
// Digit-by-digit integer square root of a 64-bit value, one root bit per cycle.
// Depends on cir_pkg; result saturated to the signed Q16.16 maximum.
module cir_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [63:0]        radicand,
  output logic               done,
  output logic signed [31:0] root
);
  import cir_pkg::*;

  localparam int SQRT_STEPS = 32;
  localparam int CNT_W = $clog2(SQRT_STEPS + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [33:0]      rem;
  logic [63:0]      xs;
  logic [31:0]      r;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;

  assign rem_sh = {rem, xs[63:62]};
  assign trial  = {2'b00, r, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        done <= 1'b0;
        busy <= 1'b1;
        cnt  <= CNT_W'(SQRT_STEPS);
        rem  <= '0;
        xs   <= radicand;
        r    <= '0;
      end else if (busy) begin
        rem  <= ge ? diff[33:0] : rem_sh[33:0];
        xs   <= {xs[61:0], 2'b00};
        r    <= {r[30:0], ge};
        cnt  <= cnt - CNT_W'(1);
        done <= (cnt == CNT_W'(1));
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign root = r[31] ? Q_MAX : $signed(r);

endmodule

// File: rtl/cir_solver.sv
// Contact sequencer: restitution, friction and position correction on two bodies.
// Depends on cir_pkg, cir_div and cir_sqrt; one registered 32x32 multiplier.
module cir_solver (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  cir_pkg::body_t    rec_a,
  input  cir_pkg::body_t    rec_b,
  input  cir_pkg::contact_t contact,
  input  logic [16:0]       corr_frac,
  input  logic [16:0]       pen_slop,
  output logic              done,
  output logic [2:0]        status,
  output cir_pkg::body_t    res_a,
  output cir_pkg::body_t    res_b
);
  import cir_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_TIM    = 5'd1;
  localparam logic [4:0] S_TCHK   = 5'd2;
  localparam logic [4:0] S_CV_M   = 5'd3;
  localparam logic [4:0] S_CV_A   = 5'd4;
  localparam logic [4:0] S_CVCHK  = 5'd5;
  localparam logic [4:0] S_J_D    = 5'd6;
  localparam logic [4:0] S_J_W    = 5'd7;
  localparam logic [4:0] S_PRE_M  = 5'd8;
  localparam logic [4:0] S_PRE_A  = 5'd9;
  localparam logic [4:0] S_APP_A  = 5'd10;
  localparam logic [4:0] S_APP_B  = 5'd11;
  localparam logic [4:0] S_APP_C  = 5'd12;
  localparam logic [4:0] S_T_M    = 5'd13;
  localparam logic [4:0] S_T_A    = 5'd14;
  localparam logic [4:0] S_SQ_M   = 5'd15;
  localparam logic [4:0] S_SQ_A   = 5'd16;
  localparam logic [4:0] S_SQ_W   = 5'd17;
  localparam logic [4:0] S_LIM_A  = 5'd18;
  localparam logic [4:0] S_DYN_A  = 5'd19;
  localparam logic [4:0] S_TH_D   = 5'd20;
  localparam logic [4:0] S_TH_W   = 5'd21;
  localparam logic [4:0] S_D3_M   = 5'd22;
  localparam logic [4:0] S_D3_A   = 5'd23;
  localparam logic [4:0] S_JT_D   = 5'd24;
  localparam logic [4:0] S_JT_W   = 5'd25;
  localparam logic [4:0] S_CORR   = 5'd26;
  localparam logic [4:0] S_CORR_W = 5'd27;
  localparam logic [4:0] S_CORR_A = 5'd28;
  localparam logic [4:0] S_FIN    = 5'd29;

  localparam logic [1:0] PH_IMP  = 2'd0;
  localparam logic [1:0] PH_FRIC = 2'd1;
  localparam logic [1:0] PH_CORR = 2'd2;

  localparam logic [1:0] HY_LEN = 2'd0;
  localparam logic [1:0] HY_MU  = 2'd1;
  localparam logic [1:0] HY_DYN = 2'd2;

  logic [4:0] state;
  logic [1:0] idx;
  logic [1:0] phase;
  logic [1:0] hsel;

  body_t       ra_rec;
  body_t       rb_rec;
  logic        same;
  logic [16:0] cfr;
  logic [16:0] slop;
  logic [16:0] e_min;
  logic [2:0]  status_r;

  logic signed [31:0] va [3];
  logic signed [31:0] vb [3];
  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];
  logic signed [31:0] nrm [3];
  logic signed [31:0] rv [3];
  logic signed [31:0] tv [3];
  logic signed [31:0] th [3];

  logic signed [31:0] ia, ib, pen, tim, cv, jimp, jt, fs, corr, tmp, len;
  logic signed [33:0] acc;
  logic [63:0]        acc64;

  logic signed [63:0] prod;
  logic signed [31:0] mul_x, mul_y, qm;

  logic               div_start, div_done;
  logic signed [31:0] div_a, div_b, div_q;
  logic               sq_start, sq_done;
  logic [63:0]        sq_sum;
  logic signed [31:0] sq_r;

  logic signed [31:0] cv_w, kk, neg_d3, d32, cf_s, hop, cur_a, cur_b;
  logic signed [31:0] app_new_a, app_new_b;
  logic signed [32:0] pen_d;
  logic signed [33:0] ajt;
  logic               sq_last;

  cir_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  cir_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_sum),
    .done     (sq_done),
    .root     (sq_r)
  );

  assign qm     = qmul_of(prod);
  assign cv_w   = sat34(acc);
  assign kk     = -($signed({15'd0, e_min}) + 32'sd65536);
  assign neg_d3 = (cv_w == Q_MIN) ? Q_MAX : -cv_w;
  assign pen_d  = 33'(pen) - $signed({16'd0, slop});
  assign d32    = pen_d[32] ? 32'sd0 : pen_d[31:0];
  assign cf_s   = $signed({15'd0, cfr});
  assign ajt    = jt[31] ? -34'(jt) : 34'(jt);
  assign sq_sum = acc64 + $unsigned(prod);
  assign sq_last = (hsel == HY_LEN) ? (idx == 2'd2) : (idx == 2'd1);

  assign cur_a     = (phase == PH_CORR) ? pa[idx] : va[idx];
  assign cur_b     = (phase == PH_CORR) ? pb[idx] : vb[idx];
  assign app_new_a = sat_sub(cur_a, qm);
  assign app_new_b = sat_add(same ? cur_a : cur_b, qm);

  always_comb begin
    case (hsel)
      HY_LEN:  hop = tv[idx];
      HY_MU:   hop = (idx == 2'd0) ? ra_rec.static_fric : rb_rec.static_fric;
      default: hop = (idx == 2'd0) ? ra_rec.dyn_fric : rb_rec.dyn_fric;
    endcase
  end

  always_comb begin
    mul_x = 32'sd0;
    mul_y = 32'sd0;
    case (state)
      S_CV_M:   begin mul_x = rv[idx]; mul_y = nrm[idx]; end
      S_CVCHK:  begin mul_x = kk;      mul_y = cv_w;     end
      S_PRE_M: begin
        if (phase == PH_FRIC) begin
          mul_x = th[idx];
          mul_y = fs;
        end else begin
          mul_x = nrm[idx];
          mul_y = (phase == PH_IMP) ? jimp : corr;
        end
      end
      S_APP_A:  begin mul_x = tmp;     mul_y = ia;       end
      S_APP_B:  begin mul_x = tmp;     mul_y = ib;       end
      S_T_M:    begin mul_x = nrm[idx]; mul_y = cv;      end
      S_SQ_M:   begin mul_x = hop;     mul_y = hop;      end
      S_SQ_W:   begin mul_x = jimp;    mul_y = sq_r;     end
      S_D3_M:   begin mul_x = rv[idx]; mul_y = th[idx];  end
      S_CORR_W: begin mul_x = div_q;   mul_y = cf_s;     end
      default:  ;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_a     = d32;
    div_b     = tim;
    case (state)
      S_J_D:   begin div_start = 1'b1; div_a = qm;      end
      S_TH_D:  begin div_start = 1'b1; div_a = tv[idx]; div_b = len; end
      S_JT_D:  begin div_start = 1'b1; div_a = neg_d3;  end
      S_CORR:  div_start = 1'b1;
      default: ;
    endcase
  end

  assign sq_start = (state == S_SQ_A) && sq_last;

  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      phase <= PH_IMP;
      hsel  <= HY_LEN;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            ra_rec <= rec_a;
            rb_rec <= rec_b;
            va[0] <= rec_a.vel_x; va[1] <= rec_a.vel_y; va[2] <= rec_a.vel_z;
            vb[0] <= rec_b.vel_x; vb[1] <= rec_b.vel_y; vb[2] <= rec_b.vel_z;
            pa[0] <= rec_a.pos_x; pa[1] <= rec_a.pos_y; pa[2] <= rec_a.pos_z;
            pb[0] <= rec_b.pos_x; pb[1] <= rec_b.pos_y; pb[2] <= rec_b.pos_z;
            ia <= rec_a.inv_mass;
            ib <= rec_b.inv_mass;
            e_min <= (rec_a.restitution < rec_b.restitution) ?
                     rec_a.restitution : rec_b.restitution;
            nrm[0] <= contact.nx; nrm[1] <= contact.ny; nrm[2] <= contact.nz;
            pen  <= contact.pen;
            same <= contact.same;
            cfr  <= corr_frac;
            slop <= pen_slop;
            state <= S_TIM;
          end
        end
        S_TIM: begin
          tim <= sat_add(ia, ib);
          for (int i = 0; i < 3; i++) rv[i] <= sat_sub(vb[i], va[i]);
          state <= S_TCHK;
        end
        S_TCHK: begin
          if (tim <= 32'sd0) begin
            status_r <= STAT_IMMOVABLE;
            state    <= S_FIN;
          end else begin
            acc   <= '0;
            idx   <= '0;
            state <= S_CV_M;
          end
        end
        S_CV_M: state <= S_CV_A;
        S_CV_A: begin
          acc <= acc + 34'(qm);
          if (idx == 2'd2) begin
            state <= S_CVCHK;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_CV_M;
          end
        end
        S_CVCHK: begin
          cv <= cv_w;
          if (cv_w > 32'sd0) begin
            status_r <= STAT_SEPARATING;
            state    <= S_FIN;
          end else begin
            state <= S_J_D;
          end
        end
        S_J_D: state <= S_J_W;
        S_J_W: begin
          if (div_done) begin
            jimp  <= div_q;
            idx   <= '0;
            phase <= PH_IMP;
            state <= S_PRE_M;
          end
        end
        S_PRE_M: state <= S_PRE_A;
        S_PRE_A: begin
          tmp   <= qm;
          state <= S_APP_A;
        end
        S_APP_A: state <= S_APP_B;
        S_APP_B: begin
          if (phase == PH_CORR) pa[idx] <= app_new_a;
          else va[idx] <= app_new_a;
          state <= S_APP_C;
        end
        S_APP_C: begin
          if (phase == PH_CORR) begin
            pb[idx] <= app_new_b;
            if (same) pa[idx] <= app_new_b;
          end else begin
            vb[idx] <= app_new_b;
            if (same) va[idx] <= app_new_b;
          end
          if (idx != 2'd2) begin
            idx   <= idx + 2'd1;
            state <= S_PRE_M;
          end else begin
            idx <= '0;
            case (phase)
              PH_IMP:  state <= S_T_M;
              PH_FRIC: state <= S_CORR;
              default: begin
                status_r <= STAT_APPLIED;
                state    <= S_FIN;
              end
            endcase
          end
        end
        S_T_M: state <= S_T_A;
        S_T_A: begin
          tv[idx] <= sat_sub(rv[idx], qm);
          if (idx == 2'd2) begin
            idx   <= '0;
            acc64 <= '0;
            hsel  <= HY_LEN;
            state <= S_SQ_M;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_T_M;
          end
        end
        S_SQ_M: state <= S_SQ_A;
        S_SQ_A: begin
          acc64 <= sq_sum;
          if (sq_last) begin
            state <= S_SQ_W;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_SQ_M;
          end
        end
        S_SQ_W: begin
          if (sq_done) begin
            idx <= '0;
            case (hsel)
              HY_LEN: begin
                len   <= sq_r;
                state <= (sq_r != 32'sd0) ? S_TH_D : S_CORR;
              end
              HY_MU:   state <= S_LIM_A;
              default: state <= S_DYN_A;
            endcase
          end
        end
        S_LIM_A: begin
          idx   <= '0;
          acc64 <= '0;
          if (ajt < 34'(qm)) begin
            fs    <= jt;
            phase <= PH_FRIC;
            state <= S_PRE_M;
          end else begin
            hsel  <= HY_DYN;
            state <= S_SQ_M;
          end
        end
        S_DYN_A: begin
          fs    <= (qm == Q_MIN) ? Q_MAX : -qm;
          phase <= PH_FRIC;
          idx   <= '0;
          state <= S_PRE_M;
        end
        S_TH_D: state <= S_TH_W;
        S_TH_W: begin
          if (div_done) begin
            th[idx] <= div_q;
            if (idx == 2'd2) begin
              idx   <= '0;
              acc   <= '0;
              state <= S_D3_M;
            end else begin
              idx   <= idx + 2'd1;
              state <= S_TH_D;
            end
          end
        end
        S_D3_M: state <= S_D3_A;
        S_D3_A: begin
          acc <= acc + 34'(qm);
          if (idx == 2'd2) begin
            state <= S_JT_D;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_D3_M;
          end
        end
        S_JT_D: state <= S_JT_W;
        S_JT_W: begin
          if (div_done) begin
            jt    <= div_q;
            hsel  <= HY_MU;
            idx   <= '0;
            acc64 <= '0;
            state <= S_SQ_M;
          end
        end
        S_CORR: state <= S_CORR_W;
        S_CORR_W: begin
          if (div_done) state <= S_CORR_A;
        end
        S_CORR_A: begin
          corr  <= qm;
          phase <= PH_CORR;
          idx   <= '0;
          state <= S_PRE_M;
        end
        S_FIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign done   = (state == S_FIN);
  assign status = status_r;

  always_comb begin
    res_a = ra_rec;
    res_a.vel_x = va[0]; res_a.vel_y = va[1]; res_a.vel_z = va[2];
    res_a.pos_x = pa[0]; res_a.pos_y = pa[1]; res_a.pos_z = pa[2];
    res_b = rb_rec;
    res_b.vel_x = vb[0]; res_b.vel_y = vb[1]; res_b.vel_z = vb[2];
    res_b.pos_x = pb[0]; res_b.pos_y = pb[1]; res_b.pos_z = pb[2];
  end

endmodule

// File: rtl/contact_impulse_resolver.sv
// Top level: body table memory, item sequencing, output register, config regs.
// Depends on cir_pkg and cir_solver.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_ready  | kind, slot_a, slot_b, value_x..value_w
//  out     | out_valid/out_ready| status, out_velocity_*, out_position_*
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// Body access items pass through T_RDA, T_RDB, T_EXEC and T_OUT, and their
// result is then registered at the output. An applied contact goes through
// T_SOLVE and T_WRB as well and runs up to six 48-step divisions and three
// 32-step square roots in the solver, all in sequence.
// After reset a clearing pass writes zero to every slot of the body memory
// while in_ready stays low. One item is in work at a time; a result waiting
// on out_ready does not block the next transfer in.
module contact_impulse_resolver #(
  parameter int BODY_SLOTS = cir_pkg::BODY_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         kind,
  input  logic [9:0]         slot_a,
  input  logic [9:0]         slot_b,
  input  logic signed [31:0] value_x,
  input  logic signed [31:0] value_y,
  input  logic signed [31:0] value_z,
  input  logic signed [31:0] value_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [31:0] out_velocity_x,
  output logic signed [31:0] out_velocity_y,
  output logic signed [31:0] out_velocity_z,
  output logic signed [31:0] out_position_x,
  output logic signed [31:0] out_position_y,
  output logic signed [31:0] out_position_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  import cir_pkg::*;

  localparam int SLOT_W = $clog2(BODY_SLOTS);
  localparam logic [16:0] SLOTS_L = 17'(BODY_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BODY_SLOTS - 1);

  localparam logic [2:0] T_CLEAR = 3'd0;
  localparam logic [2:0] T_IDLE  = 3'd1;
  localparam logic [2:0] T_RDA   = 3'd2;
  localparam logic [2:0] T_RDB   = 3'd3;
  localparam logic [2:0] T_EXEC  = 3'd4;
  localparam logic [2:0] T_SOLVE = 3'd5;
  localparam logic [2:0] T_WRB   = 3'd6;
  localparam logic [2:0] T_OUT   = 3'd7;

  logic [2:0]        state;
  logic [SLOT_W-1:0] clr_cnt;
  logic [16:0]       corr_frac;
  logic [16:0]       pen_slop;

  logic [2:0]         kind_r;
  logic [9:0]         slot_a_r;
  logic [9:0]         slot_b_r;
  logic signed [31:0] vx_r, vy_r, vz_r, vw_r;

  body_t      rec_a;
  body_t      rec_b;
  body_t      res;
  logic [2:0] status_r;

  body_t mem [BODY_SLOTS];
  body_t rd_data;
  logic [SLOT_W-1:0] raddr;
  logic [SLOT_W-1:0] waddr;
  logic              we;
  body_t             wdata;

  logic [16:0] a_ext, b_ext, in_a_ext;
  logic        a_ok, b_ok, contact_ok, show, out_load;
  body_t       merged;
  contact_t    contact;

  logic       sol_start, sol_done;
  logic [2:0] sol_status;
  body_t      sol_res_a, sol_res_b;

  assign a_ext    = {7'd0, slot_a_r};
  assign b_ext    = {7'd0, slot_b_r};
  assign in_a_ext = {7'd0, slot_a};
  assign a_ok     = a_ext < SLOTS_L;
  assign b_ok     = b_ext < SLOTS_L;
  assign contact_ok = a_ok && b_ok && rec_a.valid && rec_b.valid;
  assign show     = a_ok && res.valid;
  assign out_load = (state == T_OUT) && (!out_valid || out_ready);

  assign in_ready  = (state == T_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    merged = rec_a;
    case (kind_r)
      KIND_WR_VEL: begin
        merged.vel_x = vx_r; merged.vel_y = vy_r; merged.vel_z = vz_r;
      end
      KIND_WR_POS: begin
        merged.pos_x = vx_r; merged.pos_y = vy_r; merged.pos_z = vz_r;
      end
      default: begin
        merged.inv_mass    = vx_r;
        merged.restitution = vy_r[16:0];
        merged.static_fric = vz_r;
        merged.dyn_fric    = vw_r;
      end
    endcase
    merged.valid = 1'b1;
  end

  assign contact.nx   = vx_r;
  assign contact.ny   = vy_r;
  assign contact.nz   = vz_r;
  assign contact.pen  = vw_r;
  assign contact.same = (slot_a_r == slot_b_r);

  assign sol_start = (state == T_EXEC) && (kind_r == KIND_RESOLVE) && contact_ok;

  always_comb begin
    unique case (state)
      T_IDLE:  raddr = in_a_ext[SLOT_W-1:0];
      T_RDA:   raddr = b_ext[SLOT_W-1:0];
      default: raddr = a_ext[SLOT_W-1:0];
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = a_ext[SLOT_W-1:0];
    wdata = '0;
    case (state)
      T_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
      end
      T_EXEC: begin
        if (a_ok && (kind_r == KIND_WR_VEL || kind_r == KIND_WR_POS ||
                     kind_r == KIND_WR_MAT)) begin
          we    = 1'b1;
          wdata = merged;
        end else if (a_ok && kind_r == KIND_CLEAR) begin
          we = 1'b1;
        end
      end
      T_SOLVE: begin
        we    = sol_done && (sol_status == STAT_APPLIED);
        wdata = sol_res_a;
      end
      T_WRB: begin
        we    = 1'b1;
        waddr = b_ext[SLOT_W-1:0];
        wdata = sol_res_b;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  cir_solver u_solver (
    .clk       (clk),
    .rst       (rst),
    .start     (sol_start),
    .rec_a     (rec_a),
    .rec_b     (rec_b),
    .contact   (contact),
    .corr_frac (corr_frac),
    .pen_slop  (pen_slop),
    .done      (sol_done),
    .status    (sol_status),
    .res_a     (sol_res_a),
    .res_b     (sol_res_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      corr_frac <= CORR_FRAC_RST;
      pen_slop  <= SLOP_RST;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_CORR_FRAC: corr_frac <= cfg_data;
          REG_SLOP:      pen_slop  <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        T_CLEAR: begin
          clr_cnt <= clr_cnt + SLOT_W'(1);
          if (clr_cnt == LAST_SLOT) state <= T_IDLE;
        end
        T_IDLE: begin
          if (in_valid) begin
            kind_r   <= kind;
            slot_a_r <= slot_a;
            slot_b_r <= slot_b;
            vx_r <= value_x; vy_r <= value_y; vz_r <= value_z; vw_r <= value_w;
            state <= T_RDA;
          end
        end
        T_RDA: begin
          rec_a <= rd_data;
          state <= T_RDB;
        end
        T_RDB: begin
          rec_b <= rd_data;
          state <= T_EXEC;
        end
        T_EXEC: begin
          case (kind_r)
            KIND_RESOLVE: begin
              res      <= rec_a;
              status_r <= contact_ok ? STAT_DONE : STAT_MISSING;
              state    <= contact_ok ? T_SOLVE : T_OUT;
            end
            KIND_WR_VEL, KIND_WR_POS, KIND_WR_MAT: begin
              status_r <= STAT_DONE;
              res      <= a_ok ? merged : rec_a;
              state    <= T_OUT;
            end
            KIND_CLEAR: begin
              status_r <= STAT_DONE;
              if (a_ok) res <= '0;
              else res <= rec_a;
              state <= T_OUT;
            end
            default: begin
              status_r <= STAT_DONE;
              res      <= rec_a;
              state    <= T_OUT;
            end
          endcase
        end
        T_SOLVE: begin
          if (sol_done) begin
            status_r <= sol_status;
            if (sol_status == STAT_APPLIED) begin
              res   <= sol_res_a;
              state <= T_WRB;
            end else begin
              state <= T_OUT;
            end
          end
        end
        T_WRB: state <= T_OUT;
        T_OUT: begin
          if (out_load) begin
            status         <= status_r;
            out_velocity_x <= show ? res.vel_x : 32'sd0;
            out_velocity_y <= show ? res.vel_y : 32'sd0;
            out_velocity_z <= show ? res.vel_z : 32'sd0;
            out_position_x <= show ? res.pos_x : 32'sd0;
            out_position_y <= show ? res.pos_y : 32'sd0;
            out_position_z <= show ? res.pos_z : 32'sd0;
            state          <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  a_wrb_after_apply: assert property (@(posedge clk) disable iff (rst)
    state == T_WRB |-> $past(state) == T_SOLVE && $past(sol_status) == STAT_APPLIED)
    else $error("second body write without an applied contact");

  a_solver_done_in_solve: assert property (@(posedge clk) disable iff (rst)
    sol_done |-> state == T_SOLVE)
    else $error("solver finished outside of a contact");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == T_OUT && out_valid && !out_ready) |=> (state == T_OUT && out_valid))
    else $error("result loaded over a pending transfer");

endmodule

// File: test/cir_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the contact impulse resolver: watches input, output and register-write
// transfers, keeps its own copy of the body table and predicts each body readback.
// Depends on cir_pkg.
module cir_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         kind,
  input  logic [9:0]         slot_a,
  input  logic [9:0]         slot_b,
  input  logic signed [31:0] value_x,
  input  logic signed [31:0] value_y,
  input  logic signed [31:0] value_z,
  input  logic signed [31:0] value_w,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         status,
  input  logic signed [31:0] out_velocity_x,
  input  logic signed [31:0] out_velocity_y,
  input  logic signed [31:0] out_velocity_z,
  input  logic signed [31:0] out_position_x,
  input  logic signed [31:0] out_position_y,
  input  logic signed [31:0] out_position_z,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  import cir_pkg::*;

  typedef int vec3_t [3];

  typedef struct packed {
    logic [2:0]  st;
    logic [31:0] vx, vy, vz, px, py, pz;
  } readback_t;

  readback_t readback_q[$];

  int          vel [3][1024];
  int          pos [3][1024];
  int          imass [1024];
  int          fric_s [1024];
  int          fric_d [1024];
  logic [16:0] rest [1024];
  bit          live [1024];
  logic [16:0] corr_frac;
  logic [16:0] slop;

  function automatic int pin32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int qprod(int a, int b);
    return pin32((longint'(a) * longint'(b)) / 65536);
  endfunction

  function automatic int qquot(int a, int b);
    if (b == 0) return (a >= 0) ? 32'sh7FFFFFFF : 32'sh80000000;
    return pin32((longint'(a) * 65536) / longint'(b));
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= r + bit_v) begin
        x -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return r;
  endfunction

  function automatic int qlen(int a, int b, int c);
    longint unsigned s, r;
    s = longint'(unsigned'(longint'(a) * a)) + longint'(unsigned'(longint'(b) * b))
      + longint'(unsigned'(longint'(c) * c));
    r = root64(s);
    return (r > 64'd2147483647) ? 32'sh7FFFFFFF : int'(r);
  endfunction

  function automatic int dot3(vec3_t u, vec3_t v);
    longint s;
    s = 0;
    for (int i = 0; i < 3; i++) s += qprod(u[i], v[i]);
    return pin32(s);
  endfunction

  function automatic logic [2:0] resolve_contact(int a, int b, vec3_t n, int pen);
    int ia, ib, tim, cv, j, len, s, corr, jt, mu, lim, imp, fi, c;
    vec3_t rv, t, th;
    logic [16:0] e;
    longint d, ajt;
    if (!live[a] || !live[b]) return STAT_MISSING;
    ia = imass[a];
    ib = imass[b];
    tim = pin32(longint'(ia) + ib);
    if (tim <= 0) return STAT_IMMOVABLE;
    for (int i = 0; i < 3; i++) rv[i] = pin32(longint'(vel[i][b]) - vel[i][a]);
    cv = dot3(rv, n);
    if (cv > 0) return STAT_SEPARATING;

    e = (rest[a] < rest[b]) ? rest[a] : rest[b];
    j = qquot(qprod(pin32(-(64'sd65536 + longint'(e))), cv), tim);
    for (int i = 0; i < 3; i++) begin
      imp = qprod(n[i], j);
      vel[i][a] = pin32(longint'(vel[i][a]) - qprod(imp, ia));
      vel[i][b] = pin32(longint'(vel[i][b]) + qprod(imp, ib));
    end

    // friction along the tangent of the pre-impulse relative velocity
    for (int i = 0; i < 3; i++) t[i] = pin32(longint'(rv[i]) - qprod(n[i], cv));
    len = qlen(t[0], t[1], t[2]);
    if (len > 0) begin
      for (int i = 0; i < 3; i++) th[i] = qquot(t[i], len);
      jt = qquot(pin32(-longint'(dot3(rv, th))), tim);
      mu = qlen(fric_s[a], fric_s[b], 0);
      lim = qprod(j, mu);
      ajt = (jt < 0) ? -longint'(jt) : longint'(jt);
      if (ajt < longint'(lim)) s = jt;
      else s = pin32(-longint'(qprod(j, qlen(fric_d[a], fric_d[b], 0))));
      for (int i = 0; i < 3; i++) begin
        fi = qprod(th[i], s);
        vel[i][a] = pin32(longint'(vel[i][a]) - qprod(fi, ia));
        vel[i][b] = pin32(longint'(vel[i][b]) + qprod(fi, ib));
      end
    end

    d = longint'(pen) - longint'(slop);
    if (d < 0) d = 0;
    corr = qprod(qquot(pin32(d), tim), int'(corr_frac));
    for (int i = 0; i < 3; i++) begin
      c = qprod(n[i], corr);
      pos[i][a] = pin32(longint'(pos[i][a]) - qprod(c, ia));
      pos[i][b] = pin32(longint'(pos[i][b]) + qprod(c, ib));
    end
    return STAT_APPLIED;
  endfunction

  function automatic readback_t body_step(logic [2:0] k, int a, int b, int x, int y, int z,
                                          int w);
    readback_t rb;
    vec3_t n;
    rb = '0;
    rb.st = STAT_DONE;
    n[0] = x;
    n[1] = y;
    n[2] = z;
    case (k)
      KIND_RESOLVE: rb.st = resolve_contact(a, b, n, w);
      KIND_WR_VEL: begin
        for (int i = 0; i < 3; i++) vel[i][a] = n[i];
        live[a] = 1;
      end
      KIND_WR_POS: begin
        for (int i = 0; i < 3; i++) pos[i][a] = n[i];
        live[a] = 1;
      end
      KIND_WR_MAT: begin
        imass[a] = x;
        rest[a] = y[16:0];
        fric_s[a] = z;
        fric_d[a] = w;
        live[a] = 1;
      end
      KIND_CLEAR: begin
        for (int i = 0; i < 3; i++) begin
          vel[i][a] = 0;
          pos[i][a] = 0;
        end
        imass[a] = 0;
        rest[a] = 0;
        fric_s[a] = 0;
        fric_d[a] = 0;
        live[a] = 0;
      end
      default: ;
    endcase
    if (live[a]) begin
      rb.vx = vel[0][a];
      rb.vy = vel[1][a];
      rb.vz = vel[2][a];
      rb.px = pos[0][a];
      rb.py = pos[1][a];
      rb.pz = pos[2][a];
    end
    return rb;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    readback_t want;
    if (rst) begin
      for (int s = 0; s < 1024; s++) live[s] = 0;
      corr_frac = CORR_FRAC_RST;
      slop = SLOP_RST;
      errors = 0;
      readback_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CORR_FRAC) corr_frac = cfg_data;
        else slop = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (readback_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $realtime);
          errors++;
        end else begin
          want = readback_q.pop_front();
          report("status", 32'(status), 32'(want.st));
          report("out_velocity_x", out_velocity_x, want.vx);
          report("out_velocity_y", out_velocity_y, want.vy);
          report("out_velocity_z", out_velocity_z, want.vz);
          report("out_position_x", out_position_x, want.px);
          report("out_position_y", out_position_y, want.py);
          report("out_position_z", out_position_z, want.pz);
        end
      end
      if (in_valid && in_ready)
        readback_q = {readback_q, body_step(kind, int'(slot_a), int'(slot_b), value_x,
                                            value_y, value_z, value_w)};
    end
    pending = readback_q.size();
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// Top of the contact impulse resolver testbench: clock, reset, stimulus, receiver stalls
// and the verdict. Depends on cir_pkg, the block and cir_checker.
module testbench;
  import cir_pkg::*;

  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;
  localparam int ONE = 65536;

  logic               clk, rst;
  logic               in_valid, in_ready;
  logic [2:0]         kind;
  logic [9:0]         slot_a, slot_b;
  logic signed [31:0] value_x, value_y, value_z, value_w;
  logic               out_valid, out_ready;
  logic [2:0]         status;
  logic signed [31:0] out_velocity_x, out_velocity_y, out_velocity_z;
  logic signed [31:0] out_position_x, out_position_y, out_position_z;
  logic               cfg_valid, cfg_ready;
  logic [0:0]         cfg_index;
  logic [16:0]        cfg_data;
  int                 errors, pending;

  // which field groups (velocity, position, material) of a slot hold defined data
  bit       live [1024];
  bit [2:0] known [1024];
  int       burst_left, gap_max, hold_req, hold_seen;

  contact_impulse_resolver uut (.*);
  cir_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("tb: failure");
    $finish;
  end

  // receiver: the stall pattern is redrawn at random; long hold-off on request
  initial begin
    int left, mode, span;
    left = 0;
    mode = 0;
    span = 0;
    hold_seen = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        left = 400;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 128);
      end
      span--;
      if (left > 0) begin
        left--;
        out_ready = 0;
      end else begin
        case (mode)
          0: out_ready = 1;
          1: out_ready = $urandom_range(0, 1);
          2: out_ready = ($urandom_range(0, 3) == 0);
          default: out_ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic pause(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 0;
    end
  endtask

  task automatic push(logic [2:0] k, logic [9:0] a, logic [9:0] b, int x, int y, int z,
                      int w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      pause($urandom_range(0, gap_max));
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1;
    kind = k;
    slot_a = a;
    slot_b = b;
    value_x = x;
    value_y = y;
    value_z = z;
    value_w = w;
    do @(posedge clk); while (!in_ready);
    case (k)
      KIND_WR_VEL: begin live[a] = 1; known[a][0] = 1; end
      KIND_WR_POS: begin live[a] = 1; known[a][1] = 1; end
      KIND_WR_MAT: begin live[a] = 1; known[a][2] = 1; end
      KIND_CLEAR: begin live[a] = 0; known[a] = 3'b111; end
      default: ;
    endcase
  endtask

  task automatic set_reg(logic [0:0] idx, logic [16:0] data);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic int span_val(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic logic [9:0] pick_slot();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 10'($urandom_range(0, 11));
    if (r < 95) return 10'($urandom);
    return 10'd1023;
  endfunction

  task automatic pick_normal(output int x, output int y, output int z);
    int sg;
    sg = $urandom_range(0, 1) ? 1 : -1;
    x = 0;
    y = 0;
    z = 0;
    case ($urandom_range(0, 7))
      0: x = sg * ONE;
      1: y = sg * ONE;
      2: z = sg * ONE;
      3: begin x = sg * 39322; y = 52429; end
      4: begin y = 39322; z = sg * -52429; end
      5: begin x = sg * 37837; y = 37837; z = -37837; end
      6: begin x = span_val(ONE); y = span_val(ONE); z = span_val(ONE); end
      default: begin x = $urandom; y = $urandom; z = $urandom; end
    endcase
  endtask

  task automatic write_material(logic [9:0] s);
    int m;
    m = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(0, 2 * ONE);
    push(KIND_WR_MAT, s, 10'($urandom), m, $urandom_range(0, ONE), $urandom_range(0, ONE),
         $urandom_range(0, ONE));
  endtask

  // a live slot must never expose a field group that was never written
  task automatic prime(logic [9:0] s);
    if (live[s]) begin
      if (!known[s][0])
        push(KIND_WR_VEL, s, 10'($urandom), span_val(2 * ONE), span_val(2 * ONE),
             span_val(2 * ONE), 0);
      if (!known[s][1])
        push(KIND_WR_POS, s, 10'($urandom), span_val(8 * ONE), span_val(8 * ONE),
             span_val(8 * ONE), 0);
      if (!known[s][2]) write_material(s);
    end
  endtask

  task automatic send(logic [2:0] k, logic [9:0] a, logic [9:0] b, int x, int y, int z,
                      int w);
    if (k == KIND_RESOLVE || k == KIND_READ || k == KIND_SPARE6 || k == KIND_SPARE7) begin
      prime(a);
      if (k == KIND_RESOLVE) prime(b);
    end
    push(k, a, b, x, y, z, w);
  endtask

  task automatic random_item();
    int r, x, y, z, w;
    logic [9:0] a, b;
    r = $urandom_range(0, 99);
    a = pick_slot();
    b = pick_slot();
    if (r < 46) begin
      pick_normal(x, y, z);
      w = ($urandom_range(0, 9) == 0) ? int'($urandom) : $urandom_range(0, 8000);
      send(KIND_RESOLVE, a, b, x, y, z, w);
    end else if (r < 57) begin
      send(KIND_WR_VEL, a, b, span_val(2 * ONE), span_val(2 * ONE), span_val(2 * ONE), 0);
    end else if (r < 63) begin
      send(KIND_WR_POS, a, b, span_val(8 * ONE), span_val(8 * ONE), span_val(8 * ONE), 0);
    end else if (r < 71) begin
      write_material(a);
    end else if (r < 81) begin
      send(KIND_READ, a, b, $urandom, $urandom, $urandom, $urandom);
    end else if (r < 85) begin
      send(KIND_CLEAR, a, b, $urandom, $urandom, $urandom, $urandom);
    end else if (r < 89) begin
      send($urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7, a, b, $urandom, $urandom,
           $urandom, $urandom);
    end else begin
      send(3'($urandom), 10'($urandom), 10'($urandom), $urandom, $urandom, $urandom,
           $urandom);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    burst_left = 0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic directed();
    send(KIND_READ, 10'd5, 10'd0, 0, 0, 0, 0);
    send(KIND_SPARE7, 10'd1023, 10'd0, -1, -1, -1, -1);
    send(KIND_WR_VEL, 10'd1, 10'd0, 2 * ONE, ONE / 2, 0, 0);
    send(KIND_WR_POS, 10'd1, 10'd0, 0, 0, 0, 0);
    send(KIND_WR_MAT, 10'd1, 10'd0, ONE, ONE / 2, ONE / 2, 19661);
    send(KIND_WR_VEL, 10'd2, 10'd0, -2 * ONE, 0, 0, 0);
    send(KIND_WR_POS, 10'd2, 10'd0, ONE, 0, 0, 0);
    send(KIND_WR_MAT, 10'd2, 10'd0, ONE, ONE, 45875, 26214);
    // head-on with a tangential component, then the pair moving apart
    send(KIND_RESOLVE, 10'd1, 10'd2, ONE, 0, 0, 6554);
    send(KIND_RESOLVE, 10'd1, 10'd2, ONE, 0, 0, 6554);
    send(KIND_RESOLVE, 10'd1, 10'd3, ONE, 0, 0, 6554);
    send(KIND_WR_MAT, 10'd3, 10'd0, 0, 0, 0, 0);
    send(KIND_RESOLVE, 10'd3, 10'd3, 0, ONE, 0, 100);
    send(KIND_RESOLVE, 10'd1, 10'd1, 0, 0, ONE, 9000);
    send(KIND_WR_MAT, 10'd4, 10'd0, -ONE, ONE, ONE, ONE);
    send(KIND_RESOLVE, 10'd4, 10'd3, ONE, 0, 0, 100);
    send(KIND_WR_VEL, 10'd1023, 10'd0, 32'sh7FFFFFFF, 32'sh80000000, -1, 0);
    send(KIND_WR_POS, 10'd1023, 10'd0, 32'sh80000000, 32'sh7FFFFFFF, 0, 0);
    send(KIND_WR_MAT, 10'd1023, 10'd0, 32'sh7FFFFFFF, -1, 32'sh7FFFFFFF, 32'sh80000000);
    send(KIND_RESOLVE, 10'd1023, 10'd1, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
         32'sh7FFFFFFF);
    send(KIND_RESOLVE, 10'd1, 10'd1023, ONE, 0, 0, 32'sh80000000);
    send(KIND_CLEAR, 10'd2, 10'd0, 0, 0, 0, 0);
    send(KIND_READ, 10'd2, 10'd0, 0, 0, 0, 0);
    send(KIND_RESOLVE, 10'd1, 10'd2, ONE, 0, 0, 0);
    send(KIND_SPARE6, 10'd1, 10'd0, 0, 0, 0, 0);
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    kind = KIND_READ;
    slot_a = 0;
    slot_b = 0;
    value_x = 0;
    value_y = 0;
    value_z = 0;
    value_w = 0;
    cfg_valid = 0;
    cfg_index = REG_CORR_FRAC;
    cfg_data = 0;
    hold_req = 0;
    burst_left = 0;
    gap_max = 3;
    for (int s = 0; s < 1024; s++) begin
      live[s] = 0;
      known[s] = 3'b000;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    set_reg(REG_CORR_FRAC, CORR_FRAC_RST);
    set_reg(REG_SLOP, SLOP_RST);
    directed();
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin set_reg(REG_CORR_FRAC, 17'd0); set_reg(REG_SLOP, 17'd0); end
        1: begin set_reg(REG_CORR_FRAC, 17'd65536); set_reg(REG_SLOP, 17'd65536); end
        2: begin
          set_reg(REG_CORR_FRAC, 17'($urandom_range(0, 65536)));
          set_reg(REG_SLOP, 17'($urandom_range(0, 65536)));
        end
        3: begin set_reg(REG_CORR_FRAC, 17'h1FFFF); set_reg(REG_SLOP, 17'h1FFFF); end
        default: begin set_reg(REG_CORR_FRAC, CORR_FRAC_RST); set_reg(REG_SLOP, SLOP_RST); end
      endcase
      gap_max = (ph == 0) ? 0 : 12;
      if (ph == 2) hold_req++;
      repeat (365) random_item();
      drain();
    end
    repeat (500) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// File: contact_impulse_resolver.f
rtl/cir_pkg.sv
rtl/cir_div.sv
rtl/cir_sqrt.sv
rtl/cir_solver.sv
rtl/contact_impulse_resolver.sv
test/cir_checker.sv
test/testbench.sv
